// File: design/uscl_pkg.sv
// shared types, register indexes and the channel blend function of the upscaler
// no dependencies
package uscl_pkg;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  localparam logic [9:0]  RST_SRC_W = 10'd320;
  localparam logic [8:0]  RST_SRC_H = 9'd200;
  localparam logic [12:0] RST_DST_W = 13'd1920;
  localparam logic [12:0] RST_DST_H = 13'd1080;

  localparam logic [7:0] ALPHA = 8'hFF;

  typedef struct packed {
    logic        action;
    logic [8:0]  src_x;
    logic [7:0]  src_y;
    logic [23:0] src_rgb;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
  } item_t;

  // a + floor((b - a) * w / 256)
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] w);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic [9:0]         s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, w});
    s = {2'b00, a} + p[17:8];
    return s[7:0];
  endfunction

endpackage

// File: design/uscl_front.sv
// request intake: classifies requests and queues them for the back end
// depends on uscl_pkg
module uscl_front import uscl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        hold,
  input  logic        action,
  input  logic [8:0]  src_x,
  input  logic [7:0]  src_y,
  input  logic [23:0] src_rgb,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  output logic        busy,
  output logic        q_valid,
  output item_t       q_item
);

  item_t      fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       pop;
  item_t      in_item;

  assign busy    = hold || (count == 3'd4);
  assign push    = start && !busy;
  assign pop     = (count != 3'd0);
  assign q_valid = pop;
  assign q_item  = fifo[rd_ptr];

  always_comb begin
    in_item.action  = (action == ACT_FETCH) ? ACT_FETCH : ACT_WRITE;
    in_item.src_x   = src_x;
    in_item.src_y   = src_y;
    in_item.src_rgb = src_rgb;
    in_item.dst_x   = dst_x;
    in_item.dst_y   = dst_y;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// File: design/uscl_recip.sv
// bit-serial reciprocal: recip = floor(2^K / div), one quotient bit a cycle
// depends on uscl_pkg
module uscl_recip import uscl_pkg::*; #(
  parameter int K = 29
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [12:0] div,
  output logic        busy,
  output logic [K:0]  recip
);

  localparam int CW = $clog2(K + 1);

  logic [12:0]   rem;
  logic [CW-1:0] cnt;
  logic          run;
  logic [13:0]   trial;
  logic          qbit;

  assign busy  = run;
  // numerator is a single one at bit K
  assign trial = {rem, (cnt == CW'(K))};
  assign qbit  = (trial >= {1'b0, div});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      run <= 1'b1;
      cnt <= CW'(K);
    end else if (run) begin
      if (cnt == '0) run <= 1'b0;
      else cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= '0;
      recip <= '0;
    end else if (run) begin
      rem   <= qbit ? 13'(trial - {1'b0, div}) : trial[12:0];
      recip <= {recip[K-1:0], qbit};
    end
  end

endmodule

// File: design/uscl_map.sv
// four-stage axis mapping: clamped coordinate to neighbour indices and weight
// depends on uscl_pkg
module uscl_map import uscl_pkg::*; #(
  parameter  int IW = 9,
  localparam int K  = IW + 20
) (
  input  logic          clk,
  input  logic [11:0]   coord,
  input  logic [IW-1:0] size_m1,
  input  logic [12:0]   dlim,
  input  logic [12:0]   div,
  input  logic [K:0]    recip,
  output logic [IW-1:0] i0,
  output logic [IW-1:0] i1,
  output logic [7:0]    w
);

  localparam int MW = 12 + IW;
  localparam int PW = MW + K + 1;
  localparam int QW = IW + 8;
  localparam int DW = QW + 13;

  logic [11:0]   cc;
  logic [MW-1:0] m1;
  logic [MW-1:0] m2;
  logic [PW-1:0] prod;
  logic [QW-1:0] qe_c;
  logic [QW-1:0] qe3;
  logic [DW-1:0] qd3;
  logic [K-1:0]  n3;
  logic [DW-1:0] r;
  logic [QW-1:0] q;
  logic [IW-1:0] a;

  assign cc   = ({1'b0, coord} > dlim) ? dlim[11:0] : coord;
  assign qe_c = prod[K-8 +: QW];

  // estimate is exact or one low; one compare fixes it
  always_comb begin
    r = DW'(n3) - qd3;
    q = qe3 + QW'(r >= DW'(div));
    a = (q[QW-1:8] > size_m1) ? size_m1 : q[QW-1:8];
  end

  always_ff @(posedge clk) begin
    m1   <= MW'(cc) * MW'(size_m1);
    m2   <= m1;
    prod <= PW'(m1) * PW'(recip);
    qe3  <= qe_c;
    qd3  <= DW'(qe_c) * DW'(div);
    n3   <= {m2, 8'd0};
    i0   <= a;
    i1   <= (a == size_m1) ? a : a + IW'(1);
    w    <= q[7:0];
  end

endmodule

// File: design/uscl_back.sv
// execution pipeline: axis mapping, four parity-banked source stores, blending
// depends on uscl_pkg, uscl_map
module uscl_back import uscl_pkg::*; #(
  parameter  int MAX_SRC_W = 512,
  parameter  int MAX_SRC_H = 256,
  localparam int XW = $clog2(MAX_SRC_W),
  localparam int YW = $clog2(MAX_SRC_H)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  item_t         in_item,
  input  logic [XW-1:0] x_size_m1,
  input  logic [12:0]   x_dlim,
  input  logic [12:0]   x_div,
  input  logic [XW+20:0] x_recip,
  input  logic [YW-1:0] y_size_m1,
  input  logic [12:0]   y_dlim,
  input  logic [12:0]   y_div,
  input  logic [YW+20:0] y_recip,
  output logic          done,
  output logic [31:0]   out_pixel
);

  localparam int XA    = (XW > 1) ? XW - 1 : 1;
  localparam int YA    = (YW > 1) ? YW - 1 : 1;
  localparam int DEPTH = 2 ** (XA + YA);

  logic [23:0] bank [4][DEPTH];

  logic [3:0] vd;
  item_t      itd [4];

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [7:0]    wx, wy;

  logic [XW-1:0] col_sel [2];
  logic [YW-1:0] row_sel [2];
  logic [XA+YA-1:0] rd_addr [4];
  logic [XA+YA-1:0] wr_addr;
  logic [1:0]    wr_bank;
  logic          wr_en;

  logic [23:0] rd [4];
  logic        m_valid, m_x0p, m_y0p, m_xeq, m_yeq;
  logic [7:0]  m_wx, m_wy;

  logic [1:0]  b00, b01, b10, b11;
  logic [23:0] p00, p01, p10, p11;
  logic [7:0]  top_c [3];
  logic [7:0]  bot_c [3];
  logic        h_valid;
  logic [7:0]  h_wy;
  logic [7:0]  top [3];
  logic [7:0]  bot [3];

  uscl_map #(.IW(XW)) u_map_x (
    .clk(clk), .coord(in_item.dst_x), .size_m1(x_size_m1), .dlim(x_dlim),
    .div(x_div), .recip(x_recip), .i0(x0), .i1(x1), .w(wx)
  );

  uscl_map #(.IW(YW)) u_map_y (
    .clk(clk), .coord(in_item.dst_y), .size_m1(y_size_m1), .dlim(y_dlim),
    .div(y_div), .recip(y_recip), .i0(y0), .i1(y1), .w(wy)
  );

  // request rides alongside the mapping stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[2:0], in_valid};
    end
    itd[0] <= in_item;
    for (int i = 1; i < 4; i++) itd[i] <= itd[i-1];
  end

  // bank index is {row parity, column parity}; neighbours never share a bank unless equal
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      col_sel[p] = (x0[0] == 1'(p)) ? x0 : x1;
      row_sel[p] = (y0[0] == 1'(p)) ? y0 : y1;
    end
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = {YA'(row_sel[b/2] >> 1), XA'(col_sel[b%2] >> 1)};
    end
    wr_addr = {YA'(itd[3].src_y >> 1), XA'(itd[3].src_x >> 1)};
    wr_bank = {itd[3].src_y[0], itd[3].src_x[0]};
    wr_en   = vd[3] && (itd[3].action == ACT_WRITE)
              && (32'(itd[3].src_x) < MAX_SRC_W) && (32'(itd[3].src_y) < MAX_SRC_H);
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (wr_en && (wr_bank == 2'(b))) bank[b][wr_addr] <= itd[3].src_rgb;
      rd[b] <= bank[b][rd_addr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= vd[3] && (itd[3].action == ACT_FETCH);
    end
    m_x0p <= x0[0];
    m_y0p <= y0[0];
    m_xeq <= (x0 == x1);
    m_yeq <= (y0 == y1);
    m_wx  <= wx;
    m_wy  <= wy;
  end

  always_comb begin
    b00 = {m_y0p, m_x0p};
    b01 = {m_y0p, m_xeq ? m_x0p : !m_x0p};
    b10 = {m_yeq ? m_y0p : !m_y0p, m_x0p};
    b11 = {m_yeq ? m_y0p : !m_y0p, m_xeq ? m_x0p : !m_x0p};
    p00 = rd[b00];
    p01 = rd[b01];
    p10 = rd[b10];
    p11 = rd[b11];
    for (int c = 0; c < 3; c++) begin
      top_c[c] = lerp8(p00[16-8*c +: 8], p01[16-8*c +: 8], m_wx);
      bot_c[c] = lerp8(p10[16-8*c +: 8], p11[16-8*c +: 8], m_wx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else begin
      h_valid <= m_valid;
    end
    h_wy <= m_wy;
    for (int c = 0; c < 3; c++) begin
      top[c] <= top_c[c];
      bot[c] <= bot_c[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_valid;
    end
    out_pixel <= {ALPHA, lerp8(top[0], bot[0], h_wy), lerp8(top[1], bot[1], h_wy),
                  lerp8(top[2], bot[2], h_wy)};
  end

endmodule

// File: design/bilinear_image_upscaler.sv
// bilinear upscaler top level: configuration registers, reciprocal units, front and back
// depends on uscl_pkg, uscl_front, uscl_recip, uscl_back
//
//  channel  | handshake            | payload
//  request  | start / busy         | action, src_x, src_y, src_rgb, dst_x, dst_y
//  result   | done (one cycle)     | out_pixel
//  config   | cfg_we               | cfg_index, cfg_data
//
// one request per cycle while busy is low; done follows each fetch via the queue and back end
// after reset and after each register write, busy stays high
// while the serial units form 2^K / (dst - 1)
// the result side cannot stall; intake stops while busy is held, so the queue holds one request
module bilinear_image_upscaler import uscl_pkg::*; #(
  parameter int MAX_SRC_W = 512,
  parameter int MAX_SRC_H = 256,
  parameter int MAX_DST   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [8:0]  src_x,
  input  logic [7:0]  src_y,
  input  logic [23:0] src_rgb,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic [31:0] out_pixel
);

  localparam int XW = $clog2(MAX_SRC_W);
  localparam int YW = $clog2(MAX_SRC_H);

  logic [9:0]  src_width;
  logic [8:0]  src_height;
  logic [12:0] dst_width;
  logic [12:0] dst_height;
  logic        recalc;

  int sw_i, sh_i, dw_i, dh_i;
  logic [XW-1:0] x_size_m1;
  logic [YW-1:0] y_size_m1;
  logic [12:0]   x_dlim, y_dlim, x_div, y_div;
  logic [XW+20:0] x_recip;
  logic [YW+20:0] y_recip;
  logic          x_busy, y_busy;
  logic          q_valid;
  item_t         q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_W;
      src_height <= RST_SRC_H;
      dst_width  <= RST_DST_W;
      dst_height <= RST_DST_H;
      recalc     <= 1'b1;
    end else begin
      recalc <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_W: src_width  <= cfg_data[9:0];
          REG_SRC_H: src_height <= cfg_data[8:0];
          REG_DST_W: dst_width  <= cfg_data;
          REG_DST_H: dst_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // sizes out of range act as the nearest legal size
  always_comb begin
    sw_i = int'(src_width);
    sh_i = int'(src_height);
    dw_i = int'(dst_width);
    dh_i = int'(dst_height);
    if (sw_i < 1) sw_i = 1;
    if (sw_i > MAX_SRC_W) sw_i = MAX_SRC_W;
    if (sh_i < 1) sh_i = 1;
    if (sh_i > MAX_SRC_H) sh_i = MAX_SRC_H;
    if (dw_i < 1) dw_i = 1;
    if (dw_i > MAX_DST) dw_i = MAX_DST;
    if (dh_i < 1) dh_i = 1;
    if (dh_i > MAX_DST) dh_i = MAX_DST;
    x_size_m1 = XW'(sw_i - 1);
    y_size_m1 = YW'(sh_i - 1);
    x_dlim    = 13'(dw_i - 1);
    y_dlim    = 13'(dh_i - 1);
    x_div     = (dw_i > 1) ? 13'(dw_i - 1) : 13'd1;
    y_div     = (dh_i > 1) ? 13'(dh_i - 1) : 13'd1;
  end

  uscl_recip #(.K(XW + 20)) u_recip_x (
    .clk(clk), .rst(rst), .go(recalc), .div(x_div), .busy(x_busy), .recip(x_recip)
  );

  uscl_recip #(.K(YW + 20)) u_recip_y (
    .clk(clk), .rst(rst), .go(recalc), .div(y_div), .busy(y_busy), .recip(y_recip)
  );

  uscl_front u_front (
    .clk(clk), .rst(rst), .start(start), .hold(recalc || x_busy || y_busy),
    .action(action), .src_x(src_x), .src_y(src_y), .src_rgb(src_rgb),
    .dst_x(dst_x), .dst_y(dst_y), .busy(busy), .q_valid(q_valid), .q_item(q_item)
  );

  uscl_back #(.MAX_SRC_W(MAX_SRC_W), .MAX_SRC_H(MAX_SRC_H)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item),
    .x_size_m1(x_size_m1), .x_dlim(x_dlim), .x_div(x_div), .x_recip(x_recip),
    .y_size_m1(y_size_m1), .y_dlim(y_dlim), .y_div(y_div), .y_recip(y_recip),
    .done(done), .out_pixel(out_pixel)
  );

endmodule
